FILE: hw/rtl/ssplit_pkg.sv
// ----------------------------------------------------------------------------
// ssplit_pkg
// Shared types and constants for the s-expression statement splitter.
// ----------------------------------------------------------------------------
package ssplit_pkg;

  localparam int MAX_DEPTH = 255;
  localparam int LEN_BITS  = 16;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int OUT_LEN_W = 16;

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_SPACE,
    CC_CR,
    CC_LF,
    CC_SEMI,
    CC_BSLASH,
    CC_SQUOTE,
    CC_DQUOTE,
    CC_OPEN,
    CC_CLOSE,
    CC_EOI
  } char_class_t;

  typedef enum logic [2:0] {
    ST_INSIDE   = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_UNMATCH  = 3'd2,
    ST_ENDED    = 3'd3,
    ST_TOO_DEEP = 3'd4
  } stmt_status_t;

  typedef enum logic [1:0] {
    QT_NONE   = 2'd0,
    QT_SINGLE = 2'd1,
    QT_DOUBLE = 2'd2
  } quote_t;

  typedef struct packed {
    logic [7:0]  ch;
    char_class_t cls;
  } item_t;

  function automatic char_class_t classify(input logic [7:0] c, input logic eoi);
    char_class_t cls;
    cls = CC_OTHER;
    if (eoi) begin
      cls = CC_EOI;
    end else begin
      case (c)
        CH_SPACE, CH_TAB, CH_VT, CH_FF: cls = CC_SPACE;
        CH_CR:     cls = CC_CR;
        CH_LF:     cls = CC_LF;
        CH_SEMI:   cls = CC_SEMI;
        CH_BSLASH: cls = CC_BSLASH;
        CH_SQUOTE: cls = CC_SQUOTE;
        CH_DQUOTE: cls = CC_DQUOTE;
        CH_OPEN:   cls = CC_OPEN;
        CH_CLOSE:  cls = CC_CLOSE;
        default:   cls = CC_OTHER;
      endcase
    end
    return cls;
  endfunction

endpackage

FILE: hw/rtl/ssplit_front.sv
// ----------------------------------------------------------------------------
// ssplit_front
// Input stage: takes script bytes, classifies them and registers the item.
// ----------------------------------------------------------------------------
module ssplit_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_end_of_input,
  output logic                item_valid,
  input  logic                item_ready,
  output ssplit_pkg::item_t   item
);
  import ssplit_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.ch  <= in_ch;
      item_r.cls <= classify(in_ch, in_end_of_input);
    end
  end

endmodule

FILE: hw/rtl/ssplit_fifo.sv
// ----------------------------------------------------------------------------
// ssplit_fifo
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ssplit_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  ssplit_pkg::item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output ssplit_pkg::item_t rd_item
);
  import ssplit_pkg::*;

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: hw/rtl/ssplit_back.sv
// ----------------------------------------------------------------------------
// ssplit_back
// Statement tracker: line, quote, escape and depth state, result register.
// ----------------------------------------------------------------------------
module ssplit_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  ssplit_pkg::item_t              item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_ch,
  output logic                           out_has_char,
  output logic [2:0]                     out_status,
  output logic [ssplit_pkg::OUT_LEN_W-1:0] out_stmt_length
);
  import ssplit_pkg::*;

  localparam logic [LEN_BITS-1:0] LEN_MAX     = {LEN_BITS{1'b1}};
  localparam logic [DEPTH_W-1:0]  DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

  logic                line_start_r, line_start_nxt;
  logic                comment_r, comment_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  quote_t              quote_r, quote_nxt;
  logic                esc_r, esc_nxt;
  logic                bare_r, bare_nxt;
  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_ch_r;
  logic                out_has_r;
  stmt_status_t        out_status_r;
  logic [LEN_BITS-1:0] out_len_r;

  logic                take;
  logic                emit;
  logic                emit_has;
  stmt_status_t        emit_status;
  logic [LEN_BITS-1:0] emit_len;
  logic [LEN_BITS-1:0] count_inc;
  logic                do_keep, do_finish;
  logic [31:0]         len_wide;
  quote_t              q_of;

  assign item_ready      = !out_valid_r || out_ready;
  assign take            = item_valid && item_ready;
  assign count_inc       = (count_r == LEN_MAX) ? count_r : count_r + 1'b1;
  assign out_valid       = out_valid_r;
  assign out_ch          = out_ch_r;
  assign out_has_char    = out_has_r;
  assign out_status      = out_status_r;
  assign len_wide        = 32'(out_len_r);
  assign out_stmt_length = len_wide[OUT_LEN_W-1:0];

  always_comb begin
    line_start_nxt = line_start_r;
    comment_nxt    = comment_r;
    depth_nxt      = depth_r;
    quote_nxt      = quote_r;
    esc_nxt        = esc_r;
    bare_nxt       = bare_r;
    count_nxt      = count_r;
    do_keep        = 1'b0;
    do_finish      = 1'b0;
    emit_status    = ST_INSIDE;
    q_of           = (item.cls == CC_SQUOTE) ? QT_SINGLE : QT_DOUBLE;

    if (item.cls == CC_EOI) begin
      do_finish      = 1'b1;
      emit_status    = ST_ENDED;
      line_start_nxt = 1'b1;
      comment_nxt    = 1'b0;
    end else if (comment_r) begin
      if (item.cls == CC_LF) begin
        comment_nxt    = 1'b0;
        line_start_nxt = 1'b1;
      end
    end else if (line_start_r && (item.cls inside {CC_SPACE, CC_CR, CC_LF})) begin
      // leading whitespace and blank lines dropped
    end else if (line_start_r && item.cls == CC_SEMI) begin
      comment_nxt = 1'b1;
    end else begin
      line_start_nxt = 1'b0;
      if (esc_r) begin
        esc_nxt = 1'b0;
        do_keep = 1'b1;
      end else begin
        case (item.cls)
          CC_BSLASH: begin
            if (quote_r != QT_NONE) begin
              esc_nxt = 1'b1;
            end
            do_keep = 1'b1;
          end
          CC_SQUOTE, CC_DQUOTE: begin
            if (quote_r == QT_NONE) begin
              quote_nxt = q_of;
            end else if (quote_r == q_of) begin
              quote_nxt = QT_NONE;
            end
            do_keep = 1'b1;
          end
          CC_CR, CC_LF: begin
            if (item.cls == CC_LF) begin
              line_start_nxt = 1'b1;
            end
            if (bare_r) begin
              do_finish   = 1'b1;
              emit_status = ST_COMPLETE;
            end else begin
              do_keep = 1'b1;
            end
          end
          CC_OPEN: begin
            if (depth_r >= DEPTH_LIMIT) begin
              do_finish   = 1'b1;
              emit_status = ST_TOO_DEEP;
            end else begin
              bare_nxt  = 1'b0;
              depth_nxt = depth_r + 1'b1;
              do_keep   = 1'b1;
            end
          end
          CC_CLOSE: begin
            if (depth_r == '0) begin
              do_finish   = 1'b1;
              emit_status = ST_UNMATCH;
            end else begin
              depth_nxt = depth_r - 1'b1;
              do_keep   = 1'b1;
              if (depth_r == DEPTH_W'(1)) begin
                emit_status = ST_COMPLETE;
              end
            end
          end
          default: begin
            if (depth_r == '0) begin
              bare_nxt = 1'b1;
            end
            do_keep = 1'b1;
          end
        endcase
      end
    end

    emit     = do_keep || do_finish;
    emit_has = do_keep;
    emit_len = do_keep ? count_inc : count_r;
    if (do_keep) begin
      count_nxt = count_inc;
    end
    // any final status clears the statement
    if (emit && emit_status != ST_INSIDE) begin
      depth_nxt = '0;
      quote_nxt = QT_NONE;
      esc_nxt   = 1'b0;
      bare_nxt  = 1'b0;
      count_nxt = '0;
    end

    out_valid_nxt = out_valid_r;
    if (item_ready) begin
      out_valid_nxt = take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= 1'b1;
      comment_r    <= 1'b0;
      depth_r      <= '0;
      quote_r      <= QT_NONE;
      esc_r        <= 1'b0;
      bare_r       <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        line_start_r <= line_start_nxt;
        comment_r    <= comment_nxt;
        depth_r      <= depth_nxt;
        quote_r      <= quote_nxt;
        esc_r        <= esc_nxt;
        bare_r       <= bare_nxt;
        count_r      <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_ch_r     <= emit_has ? item.ch : 8'h00;
      out_has_r    <= emit_has;
      out_status_r <= emit_status;
      out_len_r    <= emit_len;
    end
  end

endmodule

FILE: hw/rtl/sexpr_statement_splitter.sv
// ----------------------------------------------------------------------------
// sexpr_statement_splitter
// Cuts a byte stream into s-expression statements and reports their ends.
// ----------------------------------------------------------------------------
// One script byte per beat on the input channel, sustained at one byte per
// cycle while out_ready is held high. Each byte passes a classifying input
// register, a two-entry queue and the statement tracker with its result
// register on its way to the result channel. The per-cycle limit is the
// tracker's single update of flags, depth counter and length counter.
// Dropped bytes (leading whitespace, blank and comment lines) give no result
// beat; a result beat with has_char low carries a final status only.
module sexpr_statement_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch,
  output logic        out_has_char,
  output logic [2:0]  out_status,
  output logic [15:0] out_stmt_length
);
  import ssplit_pkg::*;

  logic  front_valid, front_ready;
  item_t front_item;
  logic  queue_valid, queue_ready;
  item_t queue_item;

  ssplit_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_end_of_input (in_end_of_input),
    .item_valid      (front_valid),
    .item_ready      (front_ready),
    .item            (front_item)
  );

  ssplit_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_item  (queue_item)
  );

  ssplit_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (queue_valid),
    .item_ready      (queue_ready),
    .item            (queue_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ch          (out_ch),
    .out_has_char    (out_has_char),
    .out_status      (out_status),
    .out_stmt_length (out_stmt_length)
  );

endmodule
